// ===== hdl/track_slot_lifecycle_top_defines.svh =====
// Assertion macros shared by the track slot lifecycle RTL.
`ifndef TRACK_SLOT_LIFECYCLE_TOP_DEFINES_SVH
`define TRACK_SLOT_LIFECYCLE_TOP_DEFINES_SVH

// The expression must hold at every clock edge outside reset.
`define TSLC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define TSLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tslc_pkg.sv =====
// Types and constants shared by the track slot lifecycle block.
package tslc_pkg;

    localparam int SLOT_COUNT_DEFAULT = 8;
    localparam int MAX_ALLOC          = 8;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIRM_HIT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TENTATIVE_MISS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOST_MISS      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DROP_MISS      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEASE_FRAMES   = 3'd4;

    localparam logic [7:0] CONFIRM_HIT_RESET    = 8'd3;
    localparam logic [7:0] TENTATIVE_MISS_RESET = 8'd3;
    localparam logic [7:0] LOST_MISS_RESET      = 8'd5;
    localparam logic [7:0] DROP_MISS_RESET      = 8'd15;
    localparam logic [7:0] LEASE_FRAMES_RESET   = 8'd30;

    typedef enum logic [1:0] {
        ST_INACTIVE  = 2'd0,
        ST_TENTATIVE = 2'd1,
        ST_CONFIRMED = 2'd2,
        ST_LOST      = 2'd3
    } slot_state_t;

    typedef enum logic [1:0] {
        OP_LEASE,
        OP_HIT,
        OP_MISS,
        OP_ALLOC
    } slot_op_t;

    typedef enum logic {
        KIND_ASSIGN = 1'b0,
        KIND_STATUS = 1'b1
    } result_kind_t;

    typedef struct packed {
        slot_state_t state;
        logic [7:0]  lease;
        logic [7:0]  hits;
        logic [7:0]  misses;
    } slot_rec_t;

    typedef struct packed {
        logic [7:0] confirm_hit_threshold;
        logic [7:0] tentative_miss_limit;
        logic [7:0] lost_miss_limit;
        logic [7:0] drop_miss_limit;
        logic [7:0] lease_frames;
    } cfg_t;

    typedef struct packed {
        logic       has_detections;
        logic [7:0] hit_mask;
        logic [3:0] new_count;
    } frame_t;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  assigned_slot;
        logic [15:0] slot_states;
        logic        last;
    } result_t;

endpackage

// ===== hdl/tslc_slot_alu.sv =====
// Shared slot update unit: lease countdown, hit, miss and allocation for one slot.
module tslc_slot_alu (
    input  tslc_pkg::slot_op_t  op,
    input  tslc_pkg::cfg_t      cfg,
    input  tslc_pkg::slot_rec_t cur,
    output tslc_pkg::slot_rec_t nxt,
    output logic                release_slot
);
    import tslc_pkg::*;

    logic [7:0] hits_inc;
    logic [7:0] misses_inc;

    assign hits_inc   = (cur.hits == 8'hFF) ? cur.hits : cur.hits + 8'd1;
    assign misses_inc = (cur.misses == 8'hFF) ? cur.misses : cur.misses + 8'd1;

    always_comb
    begin
        nxt          = cur;
        release_slot = 1'b0;
        case (op)
            OP_LEASE:
            begin
                if (cur.state != ST_INACTIVE) begin
                    if (cur.lease <= 8'd1) begin
                        nxt.state    = ST_INACTIVE;
                        nxt.lease    = 8'd0;
                        nxt.hits     = 8'd0;
                        nxt.misses   = 8'd0;
                        release_slot = 1'b1;
                    end else begin
                        nxt.lease = cur.lease - 8'd1;
                    end
                end
            end
            OP_HIT:
            begin
                if (cur.state != ST_INACTIVE) begin
                    nxt.lease  = cfg.lease_frames;
                    nxt.hits   = hits_inc;
                    nxt.misses = 8'd0;
                    if (cur.state == ST_TENTATIVE) begin
                        if (hits_inc >= cfg.confirm_hit_threshold) begin
                            nxt.state = ST_CONFIRMED;
                        end
                    end else if (cur.state == ST_LOST) begin
                        nxt.state = ST_CONFIRMED;
                    end
                end
            end
            OP_MISS:
            begin
                if (cur.state != ST_INACTIVE) begin
                    nxt.misses = misses_inc;
                    nxt.hits   = 8'd0;
                    // A slot freed by misses keeps its lease and tallies until reallocated.
                    case (cur.state)
                        ST_TENTATIVE:
                        begin
                            if (misses_inc >= cfg.tentative_miss_limit) begin
                                nxt.state    = ST_INACTIVE;
                                release_slot = 1'b1;
                            end
                        end
                        ST_CONFIRMED:
                        begin
                            if (misses_inc >= cfg.lost_miss_limit) begin
                                nxt.state = ST_LOST;
                            end
                        end
                        ST_LOST:
                        begin
                            if (misses_inc >= cfg.drop_miss_limit) begin
                                nxt.state    = ST_INACTIVE;
                                release_slot = 1'b1;
                            end
                        end
                        default:
                        begin
                            nxt.state = cur.state;
                        end
                    endcase
                end
            end
            OP_ALLOC:
            begin
                nxt.state  = ST_TENTATIVE;
                nxt.lease  = cfg.lease_frames;
                nxt.hits   = 8'd1;
                nxt.misses = 8'd0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ===== hdl/track_slot_lifecycle_top.sv =====
// Track slot lifecycle manager: slot table, free-slot FIFO and frame sequencer.
//
// Each frame transaction walks the slot table one slot per cycle through a single shared
// slot update unit. One pass counts down leases. A second pass applies hits or misses,
// and it is skipped on the first frame with detections. Each allocation then pops the
// free FIFO and updates the slot in S_ALLOC, and presents the assignment in S_EMIT.
// S_ALLOC then finds that no more allocations are due, and S_STATUS presents the
// end-of-frame status. The first frame with detections allocates one slot without the
// update pass. The result side can hold S_EMIT and S_STATUS by stalling. The frame
// channel stalls while a frame is in work; the next frame is taken while the final
// status still waits in the output register.
module track_slot_lifecycle_top #(
    parameter int SLOT_COUNT = tslc_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 frame_valid,
    output logic                                 frame_stall,
    input  tslc_pkg::frame_t                     frame,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output tslc_pkg::result_t                    result,
    input  logic                                 cfg_we,
    input  logic [tslc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tslc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tslc_pkg::*;
    `include "track_slot_lifecycle_top_defines.svh"

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int PACK_N = (SLOT_COUNT < 8) ? SLOT_COUNT : 8;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(SLOT_COUNT);
    localparam logic [SUM_W-1:0]  WRAP_SUM  = SUM_W'(SLOT_COUNT);
    localparam logic [3:0]        ALLOC_CAP = 4'(MAX_ALLOC);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEASE,
        S_UPDATE,
        S_ALLOC,
        S_EMIT,
        S_STATUS
    } seq_state_t;

    seq_state_t              state_reg, state_next;
    slot_rec_t               rec_reg [SLOT_COUNT];
    logic [SLOT_W-1:0]       fifo_reg [SLOT_COUNT];
    logic [CNT_W-1:0]        free_count_reg, free_count_next;
    logic [SLOT_W-1:0]       fifo_head_reg, fifo_head_next;
    logic                    started_reg, started_next;
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic [3:0]              alloc_left_reg, alloc_left_next;
    frame_t                  frame_reg, frame_next;
    cfg_t                    cfg_reg;
    logic                    result_valid_reg, result_valid_next;
    result_t                 result_reg, result_next;

    slot_op_t                alu_op;
    slot_rec_t               alu_cur;
    slot_rec_t               alu_nxt;
    logic                    alu_release;
    logic                    wr_en;
    logic [SLOT_W-1:0]       wr_addr;
    logic                    push_en;
    logic [SLOT_W-1:0]       push_addr;
    logic [SUM_W-1:0]        tail_sum;
    logic                    result_free;
    logic                    alloc_go;
    logic                    hit_bit;
    logic [15:0]             packed_states;
    logic [SLOT_COUNT-1:0]   active_vec;

    tslc_slot_alu u_slot_alu (
        .op           (alu_op),
        .cfg          (cfg_reg),
        .cur          (alu_cur),
        .nxt          (alu_nxt),
        .release_slot (alu_release)
    );

    assign frame_stall  = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign result_free  = !result_valid_reg || !result_stall;
    assign alloc_go     = (alloc_left_reg != 4'd0) && (free_count_reg != '0);
    assign alu_cur      = rec_reg[idx_reg];
    assign hit_bit      = frame_reg.has_detections && (int'(idx_reg) < 8)
                          && frame_reg.hit_mask[3'(idx_reg)];

    // Tail of the free FIFO; head + count stays below twice the depth.
    always_comb
    begin
        tail_sum = SUM_W'(fifo_head_reg) + SUM_W'(free_count_reg);
        if (tail_sum >= WRAP_SUM)
        begin
            tail_sum = tail_sum - WRAP_SUM;
        end
        push_addr = SLOT_W'(tail_sum);
    end

    always_comb
    begin
        packed_states = '0;
        for (int i = 0; i < PACK_N; i++)
        begin
            packed_states[2*i +: 2] = rec_reg[i].state;
        end
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            active_vec[i] = (rec_reg[i].state != ST_INACTIVE);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        free_count_next   = free_count_reg;
        fifo_head_next    = fifo_head_reg;
        started_next      = started_reg;
        idx_next          = idx_reg;
        alloc_left_next   = alloc_left_reg;
        frame_next        = frame_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        alu_op            = OP_LEASE;
        wr_en             = 1'b0;
        wr_addr           = idx_reg;
        push_en           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    frame_next = frame;
                    idx_next   = '0;
                    state_next = S_LEASE;
                end
            end
            S_LEASE:
            begin
                alu_op  = OP_LEASE;
                wr_en   = 1'b1;
                push_en = alu_release;
                idx_next = idx_reg + SLOT_W'(1);
                if (idx_reg == LAST_SLOT)
                begin
                    idx_next = '0;
                    if (!frame_reg.has_detections)
                    begin
                        alloc_left_next = 4'd0;
                        state_next      = S_UPDATE;
                    end
                    else if (!started_reg)
                    begin
                        started_next    = 1'b1;
                        alloc_left_next = 4'd1;
                        state_next      = S_ALLOC;
                    end
                    else
                    begin
                        alloc_left_next = (frame_reg.new_count > ALLOC_CAP)
                                          ? ALLOC_CAP : frame_reg.new_count;
                        state_next      = S_UPDATE;
                    end
                end
            end
            S_UPDATE:
            begin
                alu_op  = hit_bit ? OP_HIT : OP_MISS;
                wr_en   = 1'b1;
                push_en = alu_release;
                idx_next = idx_reg + SLOT_W'(1);
                if (idx_reg == LAST_SLOT)
                begin
                    idx_next   = '0;
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                if (alloc_go)
                begin
                    alu_op          = OP_ALLOC;
                    wr_en           = 1'b1;
                    wr_addr         = fifo_reg[fifo_head_reg];
                    idx_next        = fifo_reg[fifo_head_reg];
                    fifo_head_next  = (fifo_head_reg == LAST_SLOT)
                                      ? '0 : fifo_head_reg + SLOT_W'(1);
                    free_count_next = free_count_reg - CNT_W'(1);
                    alloc_left_next = alloc_left_reg - 4'd1;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_EMIT:
            begin
                if (result_free)
                begin
                    result_valid_next         = 1'b1;
                    result_next.result_kind   = KIND_ASSIGN;
                    result_next.assigned_slot = 3'(idx_reg);
                    result_next.slot_states   = packed_states;
                    result_next.last          = 1'b0;
                    state_next                = S_ALLOC;
                end
            end
            S_STATUS:
            begin
                if (result_free)
                begin
                    result_valid_next         = 1'b1;
                    result_next.result_kind   = KIND_STATUS;
                    result_next.assigned_slot = 3'd0;
                    result_next.slot_states   = packed_states;
                    result_next.last          = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Pushes and pops never fall in the same cycle.
        if (push_en && (free_count_reg < FULL_CNT))
        begin
            free_count_next = free_count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            free_count_reg   <= FULL_CNT;
            fifo_head_reg    <= '0;
            started_reg      <= 1'b0;
            idx_reg          <= '0;
            alloc_left_reg   <= 4'd0;
            result_valid_reg <= 1'b0;
            cfg_reg.confirm_hit_threshold <= CONFIRM_HIT_RESET;
            cfg_reg.tentative_miss_limit  <= TENTATIVE_MISS_RESET;
            cfg_reg.lost_miss_limit       <= LOST_MISS_RESET;
            cfg_reg.drop_miss_limit       <= DROP_MISS_RESET;
            cfg_reg.lease_frames          <= LEASE_FRAMES_RESET;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                rec_reg[i]  <= '{state: ST_INACTIVE, lease: 8'd0, hits: 8'd0, misses: 8'd0};
                fifo_reg[i] <= SLOT_W'(i);
            end
        end
        else
        begin
            state_reg        <= state_next;
            free_count_reg   <= free_count_next;
            fifo_head_reg    <= fifo_head_next;
            started_reg      <= started_next;
            idx_reg          <= idx_next;
            alloc_left_reg   <= alloc_left_next;
            result_valid_reg <= result_valid_next;
            if (wr_en)
            begin
                rec_reg[wr_addr] <= alu_nxt;
            end
            if (push_en && (free_count_reg < FULL_CNT))
            begin
                fifo_reg[push_addr] <= idx_reg;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CONFIRM_HIT:    cfg_reg.confirm_hit_threshold <= cfg_data;
                    CFG_TENTATIVE_MISS: cfg_reg.tentative_miss_limit  <= cfg_data;
                    CFG_LOST_MISS:      cfg_reg.lost_miss_limit       <= cfg_data;
                    CFG_DROP_MISS:      cfg_reg.drop_miss_limit       <= cfg_data;
                    CFG_LEASE_FRAMES:   cfg_reg.lease_frames          <= cfg_data;
                    default:            cfg_reg                       <= cfg_reg;
                endcase
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        result_reg <= result_next;
    end

    `TSLC_ASSERT_ALWAYS(a_free_count_bound, free_count_reg <= FULL_CNT,
        "free slot count exceeds the slot count")
    `TSLC_ASSERT_ALWAYS(a_slots_conserved,
        ($countones(active_vec) + int'(free_count_reg)) == SLOT_COUNT,
        "active slots plus free slots do not add up to the slot count")
    `TSLC_ASSERT_NEXT(a_pop_decrements, (state_reg == S_ALLOC) && alloc_go,
        (free_count_reg == CNT_W'($past(free_count_reg) - CNT_W'(1))) && (state_reg == S_EMIT),
        "allocation did not take exactly one slot from the free FIFO")
    `TSLC_ASSERT_NEXT(a_busy_after_accept, frame_valid && !frame_stall, frame_stall,
        "frame channel not stalled while a frame transaction is in work")

endmodule
